FILE: sv/stg_pkg.sv
`timescale 1ns / 1ps

package stg_pkg;

   // Field and register widths
   localparam int SAMPLE_WIDTH_DEF = 16;
   localparam int SR_W             = 18;
   localparam int TONE_W           = 16;
   localparam int PHASE_W          = 18;
   localparam int CSR_INDEX_W      = 1;
   localparam int CSR_DATA_W       = 18;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_SAMPLE_RATE = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TONE_HZ     = 1'b1;

   // Register reset values
   localparam logic [SR_W-1:0]   SR_RESET   = 18'd48000;
   localparam logic [TONE_W-1:0] TONE_RESET = 16'd262;

   // Fixed point: angles and sine terms are Q29
   localparam int FRAC_W = 29;
   localparam int X_W    = 30;
   localparam int X2_W   = 31;
   localparam int T_W    = 30;
   localparam int NUM_W  = 26;
   localparam logic [T_W-1:0] T_ONE = 30'd536870912;

   // Serial divider sizing
   localparam int DVD_W  = 55;
   localparam int DVS_W  = 23;
   localparam int QM_W   = 32;
   localparam int DCNT_W = 6;
   localparam logic [DCNT_W-1:0] STEPS_PERIOD = 6'd18;
   localparam logic [DCNT_W-1:0] STEPS_ANGLE  = 6'd55;

   // 2*pi and pi in Q29
   localparam logic [QM_W-1:0] TWO_PI_Q = 32'd3373259426;
   localparam logic [QM_W-1:0] PI_Q     = 32'd1686629713;

   // Angle scale: 6.28 = 157 / 25
   localparam logic [7:0] NUM_SCALE = 8'd157;
   localparam logic [4:0] DEN_SCALE = 5'd25;

   // Shared multiplier
   localparam int MUL_W  = 32;
   localparam int PROD_W = 64;

   // Horner term sequence
   localparam int TERM_IDX_W = 3;
   localparam int RCP_SH_W   = 6;
   localparam logic [TERM_IDX_W-1:0] TERM_LAST = 3'd4;

   // Reciprocal of each Horner divisor, exact for dividends below 2^31
   function automatic logic [MUL_W-1:0] term_rcp(input logic [TERM_IDX_W-1:0] idx);
      logic [MUL_W-1:0] m;
      case (idx)
         3'd0:    m = 32'd2498890064;   // divide by 110
         3'd1:    m = 32'd3817748708;   // divide by 72
         3'd2:    m = 32'd3272356036;   // divide by 42
         3'd3:    m = 32'd3435973837;   // divide by 20
         default: m = 32'd2863311531;   // divide by 6
      endcase
      return m;
   endfunction

   // Right shift that goes with each reciprocal
   function automatic logic [RCP_SH_W-1:0] term_shift(input logic [TERM_IDX_W-1:0] idx);
      logic [RCP_SH_W-1:0] s;
      case (idx)
         3'd0:    s = 6'd38;
         3'd1:    s = 6'd38;
         3'd2:    s = 6'd37;
         3'd3:    s = 6'd36;
         default: s = 6'd34;
      endcase
      return s;
   endfunction

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV_P,
      ST_MUL_NUM,
      ST_MUL_DEN,
      ST_DIV_A_GO,
      ST_DIV_A,
      ST_MUL_X2,
      ST_MUL_R,
      ST_SET_T,
      ST_MUL_T,
      ST_MUL_S,
      ST_MUL_M,
      ST_EMIT
   } ctrl_state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_DIV_PERIOD,
      OP_SET_PERIOD,
      OP_MUL_NUM,
      OP_MUL_DEN,
      OP_DIV_ANGLE,
      OP_FOLD,
      OP_MUL_X2,
      OP_MUL_RCP,
      OP_SET_TERM,
      OP_MUL_TERM,
      OP_MUL_SIN,
      OP_MUL_AMP,
      OP_EMIT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic div_busy;
      logic last_term;
   } dp_status_type;

endpackage

FILE: sv/stg_div.sv
`timescale 1ns / 1ps

module stg_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [stg_pkg::DVD_W-1:0]  dividend,
   input  logic [stg_pkg::DVS_W-1:0]  divisor,
   input  logic [stg_pkg::DCNT_W-1:0] steps,
   output logic                       busy,
   output logic [stg_pkg::QM_W-1:0]   quotient
);
   import stg_pkg::*;

   logic [DCNT_W-1:0] cnt_ff, cnt_in;
   logic [DVD_W-1:0]  dvd_ff, dvd_in;
   logic [DVS_W-1:0]  dvs_ff, dvs_in;
   logic [DVS_W-1:0]  rem_ff, rem_in;
   logic [QM_W-1:0]   qm_ff, qm_in;

   logic [DVS_W:0]    trial;
   logic [DVS_W:0]    trial_diff;
   logic              trial_ge;
   logic [QM_W:0]     q_shift;
   logic [QM_W:0]     q_diff;

   // One restoring step: shift in the next dividend bit, subtract if it fits
   always_comb begin
      trial      = {rem_ff, dvd_ff[DVD_W-1]};
      trial_diff = trial - {1'b0, dvs_ff};
      trial_ge   = trial >= {1'b0, dvs_ff};
      // Keep the quotient reduced modulo 2*pi as its bits arrive
      q_shift    = {qm_ff, trial_ge};
      q_diff     = q_shift - {1'b0, TWO_PI_Q};
   end

   always_comb begin
      cnt_in = cnt_ff;
      dvd_in = dvd_ff;
      dvs_in = dvs_ff;
      rem_in = rem_ff;
      qm_in  = qm_ff;
      if (start) begin
         cnt_in = steps;
         dvd_in = dividend;
         dvs_in = divisor;
         rem_in = '0;
         qm_in  = '0;
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - 1'b1;
         dvd_in = {dvd_ff[DVD_W-2:0], 1'b0};
         rem_in = trial_ge ? trial_diff[DVS_W-1:0] : trial[DVS_W-1:0];
         qm_in  = (q_shift >= {1'b0, TWO_PI_Q}) ? q_diff[QM_W-1:0] : q_shift[QM_W-1:0];
      end
   end

   // Hold the step count under reset
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
      qm_ff  <= qm_in;
   end

   assign busy     = cnt_ff != '0;
   assign quotient = qm_ff;

endmodule

FILE: sv/stg_dp.sv
`timescale 1ns / 1ps

module stg_dp #(
   parameter int SAMPLE_WIDTH = stg_pkg::SAMPLE_WIDTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  stg_pkg::dp_cmd_type                  cmd,
   output stg_pkg::dp_status_type               status,
   input  logic                                 csr_we,
   input  logic [stg_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [stg_pkg::CSR_DATA_W-1:0]       csr_wdata,
   output logic signed [SAMPLE_WIDTH-1:0]       rsp_sample,
   output logic                                 rsp_period_start
);
   import stg_pkg::*;

   localparam int MAG_W = PROD_W - FRAC_W;
   localparam logic [MUL_W-1:0] AMP = MUL_W'((64'd1 << (SAMPLE_WIDTH - 1)) - 64'd1);
   localparam logic [PROD_W-1:0] HALF_LSB = PROD_W'(64'd1 << (FRAC_W - 1));

   // Configuration and phase state
   logic [SR_W-1:0]       sample_rate_ff;
   logic [TONE_W-1:0]     tone_ff;
   logic [PHASE_W-1:0]    phase_ff, phase_in;

   // Working registers
   logic [SR_W-1:0]       period_ff, period_in;
   logic [NUM_W-1:0]      num_ff;
   logic [PROD_W-1:0]     prod_ff;
   logic                  neg_ff, neg_in;
   logic [X_W-1:0]        x_ff, x_in;
   logic [X2_W-1:0]       x2_ff;
   logic [T_W-1:0]        t_ff, t_in;
   logic [TERM_IDX_W-1:0] hstep_ff;
   logic [SAMPLE_WIDTH-1:0] sample_ff, sample_in;
   logic                  pstart_ff;

   // Divider hookup
   logic                  div_start;
   logic [DVD_W-1:0]      div_dividend;
   logic [DVS_W-1:0]      div_divisor;
   logic [DCNT_W-1:0]     div_steps;
   logic                  div_busy;
   logic [QM_W-1:0]       div_quot;

   logic [TONE_W-1:0]     tone_eff;
   logic [X2_W-1:0]       prod_hi;
   logic [T_W-1:0]        rcp_q;

   // Multiplier
   logic                  mul_en;
   logic [MUL_W-1:0]      mul_a, mul_b;

   // Fold and output shaping
   logic [QM_W-1:0]       a_red;
   logic [QM_W-1:0]       a_fold;
   logic [QM_W:0]         a_dbl;
   logic [PROD_W-1:0]     round_sum;
   logic [MAG_W-1:0]      mag_raw;
   logic [MUL_W-1:0]      mag;
   logic [SAMPLE_WIDTH-1:0] mag_s;
   logic [PHASE_W:0]      phase_inc;

   assign tone_eff = (tone_ff == '0) ? TONE_W'(1) : tone_ff;
   assign prod_hi  = prod_ff[FRAC_W+X2_W-1:FRAC_W];

   // Select the dividend, divisor and step count for each division
   always_comb begin
      div_start    = 1'b0;
      div_dividend = {sample_rate_ff, {(DVD_W-SR_W){1'b0}}};
      div_divisor  = {{(DVS_W-TONE_W){1'b0}}, tone_eff};
      div_steps    = STEPS_PERIOD;
      case (cmd.op)
         OP_DIV_PERIOD: begin
            div_start = 1'b1;
         end
         OP_DIV_ANGLE: begin
            div_start    = 1'b1;
            div_dividend = {num_ff, {FRAC_W{1'b0}}};
            div_divisor  = prod_ff[DVS_W-1:0];
            div_steps    = STEPS_ANGLE;
         end
         default: begin
         end
      endcase
   end

   stg_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .steps    (div_steps),
      .busy     (div_busy),
      .quotient (div_quot)
   );

   // Pick multiplier operands
   always_comb begin
      mul_en = 1'b1;
      mul_a  = '0;
      mul_b  = '0;
      case (cmd.op)
         OP_MUL_NUM: begin
            mul_a = {{(MUL_W-8){1'b0}}, NUM_SCALE};
            mul_b = {{(MUL_W-PHASE_W){1'b0}}, phase_ff};
         end
         OP_MUL_DEN: begin
            mul_a = {{(MUL_W-5){1'b0}}, DEN_SCALE};
            mul_b = {{(MUL_W-SR_W){1'b0}}, period_ff};
         end
         OP_MUL_X2: begin
            mul_a = {{(MUL_W-X_W){1'b0}}, x_ff};
            mul_b = {{(MUL_W-X_W){1'b0}}, x_ff};
         end
         OP_MUL_RCP: begin
            mul_a = {{(MUL_W-X2_W){1'b0}}, prod_hi};
            mul_b = term_rcp(hstep_ff);
         end
         OP_MUL_TERM: begin
            mul_a = {{(MUL_W-X2_W){1'b0}}, x2_ff};
            mul_b = {{(MUL_W-T_W){1'b0}}, t_ff};
         end
         OP_MUL_SIN: begin
            mul_a = {{(MUL_W-X_W){1'b0}}, x_ff};
            mul_b = {{(MUL_W-T_W){1'b0}}, t_ff};
         end
         OP_MUL_AMP: begin
            mul_a = {{(MUL_W-X_W){1'b0}}, prod_ff[FRAC_W+X_W-1:FRAC_W]};
            mul_b = AMP;
         end
         default: begin
            mul_en = 1'b0;
         end
      endcase
   end

   // Reduce the angle to the first quadrant and note the sign
   always_comb begin
      a_red  = (div_quot >= PI_Q) ? div_quot - PI_Q : div_quot;
      neg_in = div_quot >= PI_Q;
      a_dbl  = {a_red, 1'b0};
      a_fold = (a_dbl > {1'b0, PI_Q}) ? PI_Q - a_red : a_red;
      x_in   = a_fold[X_W-1:0];
   end

   assign period_in = (div_quot[SR_W-1:0] == '0) ? SR_W'(1) : div_quot[SR_W-1:0];

   // Scale the reciprocal product back down to the term quotient
   assign rcp_q     = T_W'(prod_ff >> term_shift(hstep_ff));
   assign t_in      = T_ONE - rcp_q;

   // Round half up, clamp to full scale, apply sign
   always_comb begin
      round_sum = prod_ff + HALF_LSB;
      mag_raw   = round_sum[PROD_W-1:FRAC_W];
      mag       = (mag_raw > {{(MAG_W-MUL_W){1'b0}}, AMP}) ? AMP : mag_raw[MUL_W-1:0];
      mag_s     = mag[SAMPLE_WIDTH-1:0];
      sample_in = neg_ff ? (~mag_s + 1'b1) : mag_s;
   end

   // Advance the phase, wrapping at the period
   always_comb begin
      phase_inc = {1'b0, phase_ff} + 1'b1;
      phase_in  = (phase_inc >= {1'b0, period_ff}) ? '0 : phase_inc[PHASE_W-1:0];
   end

   // Configuration, phase and term index
   always_ff @(posedge clock) begin
      if (reset) begin
         sample_rate_ff <= SR_RESET;
         tone_ff        <= TONE_RESET;
         phase_ff       <= '0;
         hstep_ff       <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_SAMPLE_RATE: sample_rate_ff <= csr_wdata[SR_W-1:0];
               CSR_TONE_HZ:     tone_ff        <= csr_wdata[TONE_W-1:0];
               default: begin
               end
            endcase
         end
         if (cmd.op == OP_EMIT) begin
            phase_ff <= phase_in;
         end
         if (cmd.op == OP_FOLD) begin
            hstep_ff <= '0;
         end else if (cmd.op == OP_SET_TERM) begin
            hstep_ff <= hstep_ff + 1'b1;
         end
      end
   end

   // Working registers load on their commands
   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff <= mul_a * mul_b;
      end
      if (cmd.op == OP_SET_PERIOD) begin
         period_ff <= period_in;
      end
      if (cmd.op == OP_MUL_DEN) begin
         num_ff <= prod_ff[NUM_W-1:0];
      end
      if (cmd.op == OP_FOLD) begin
         neg_ff <= neg_in;
         x_ff   <= x_in;
      end
      if (cmd.op == OP_MUL_RCP && hstep_ff == '0) begin
         x2_ff <= prod_hi;
      end
      if (cmd.op == OP_SET_TERM) begin
         t_ff <= t_in;
      end
      if (cmd.op == OP_EMIT) begin
         sample_ff <= sample_in;
         pstart_ff <= phase_ff == '0;
      end
   end

   assign status.div_busy  = div_busy;
   assign status.last_term = hstep_ff == TERM_LAST;

   assign rsp_sample       = sample_ff;
   assign rsp_period_start = pstart_ff;

endmodule

FILE: sv/stg_ctrl.sv
`timescale 1ns / 1ps

module stg_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_tick,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output stg_pkg::dp_cmd_type    cmd,
   input  stg_pkg::dp_status_type status
);
   import stg_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;

   // Sequence the period division, angle division, Horner steps and output emit
   always_comb begin
      state_in  = state_ff;
      cmd.op    = OP_NONE;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid && req_tick) begin
               cmd.op   = OP_DIV_PERIOD;
               state_in = ST_DIV_P;
            end
         end
         ST_DIV_P: begin
            if (!status.div_busy) begin
               cmd.op   = OP_SET_PERIOD;
               state_in = ST_MUL_NUM;
            end
         end
         ST_MUL_NUM: begin
            cmd.op   = OP_MUL_NUM;
            state_in = ST_MUL_DEN;
         end
         ST_MUL_DEN: begin
            cmd.op   = OP_MUL_DEN;
            state_in = ST_DIV_A_GO;
         end
         ST_DIV_A_GO: begin
            cmd.op   = OP_DIV_ANGLE;
            state_in = ST_DIV_A;
         end
         ST_DIV_A: begin
            if (!status.div_busy) begin
               cmd.op   = OP_FOLD;
               state_in = ST_MUL_X2;
            end
         end
         ST_MUL_X2: begin
            cmd.op   = OP_MUL_X2;
            state_in = ST_MUL_R;
         end
         ST_MUL_R: begin
            cmd.op   = OP_MUL_RCP;
            state_in = ST_SET_T;
         end
         ST_SET_T: begin
            cmd.op   = OP_SET_TERM;
            state_in = status.last_term ? ST_MUL_S : ST_MUL_T;
         end
         ST_MUL_T: begin
            cmd.op   = OP_MUL_TERM;
            state_in = ST_MUL_R;
         end
         ST_MUL_S: begin
            cmd.op   = OP_MUL_SIN;
            state_in = ST_MUL_M;
         end
         ST_MUL_M: begin
            cmd.op   = OP_MUL_AMP;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            // Wait until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op   = OP_EMIT;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold the result until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.op == OP_EMIT) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: sv/sine_tone_generator_core.sv
`timescale 1ns / 1ps
// An accepted tick item runs the period and angle divisions on the shared bit-serial
// divider (18 period steps, 55 angle steps) and then the five Horner terms.
// No new item is taken before the last result is emitted, which stalls on a full output;
// an item with tick low is taken while idle and gives no result.
// Reset (synchronous, active high): sample_rate 48000, tone_hz 262, phase 0, no item.

module sine_tone_generator_core #(
   parameter int SAMPLE_WIDTH = stg_pkg::SAMPLE_WIDTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_tick,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic signed [SAMPLE_WIDTH-1:0]   rsp_sample,
   output logic                             rsp_period_start,
   input  logic                             csr_we,
   input  logic [stg_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [stg_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import stg_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   stg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_tick  (req_tick),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   stg_dp #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_sample       (rsp_sample),
      .rsp_period_start (rsp_period_start)
   );

endmodule

FILE: sv/stg_checker.sv
`timescale 1ns / 1ps

module stg_checker #(
   parameter int SAMPLE_WIDTH = stg_pkg::SAMPLE_WIDTH_DEF
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            req_tick,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic signed [SAMPLE_WIDTH-1:0]  rsp_sample,
   input logic                            rsp_period_start,
   input logic                            csr_we
);
   localparam logic [SAMPLE_WIDTH-1:0] MOST_NEG = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

   // A stalled result holds
   rsp_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample)
                                  && $stable(rsp_period_start))
      else $error("result changed while stalled");

   // A tick item keeps the block busy on the next cycle
   tick_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_tick |=> !req_ready)
      else $error("ready high right after a tick item");

   // An item with tick low is dropped and the block stays ready
   idle_drop: assert property (@(posedge clock) disable iff (reset || csr_we)
      req_valid && req_ready && !req_tick |=> req_ready)
      else $error("item with tick low made the block busy");

   // Magnitude is clamped to full scale, so the most negative code never shows
   sample_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_sample != MOST_NEG)
      else $error("sample outside full scale");

   // Reset leaves no result pending and the input open
   reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("state not cleared by reset");

endmodule

bind sine_tone_generator_core stg_checker #(
   .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_stg_checker (.*);

FILE: test/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import stg_pkg::*;

   localparam int SAMPLE_W = SAMPLE_WIDTH_DEF;
   localparam int HALF_PERIOD_NS = 6;
   localparam int RESET_CYCLES = 7;
   // Well above the time from a tick item to its result
   localparam int SETTLE_CYCLES = 260;
   localparam int HOLD_CYCLES = 3000;
   localparam int RANDOM_PHASES = 12;
   localparam int TICKS_PER_PHASE = 45;
   localparam longint TIMEOUT_NS = 64'd12_000_000;

   // Q29 angle arithmetic; the angle scale takes 2*pi as 6.28 (157 / 25)
   localparam int FRAC = 29;
   localparam bit [63:0] Q29_ONE = 64'd1 << FRAC;
   localparam bit [63:0] Q29_HALF = 64'd1 << (FRAC - 1);
   localparam bit [63:0] ANGLE_FULL_TURN = 64'd3373259426;
   localparam bit [63:0] ANGLE_HALF_TURN = 64'd1686629713;
   localparam bit [63:0] FULL_SCALE = (64'd1 << (SAMPLE_W - 1)) - 64'd1;

   typedef struct {
      logic [SAMPLE_W-1:0] value;
      logic                starts_period;
   } tone_sample_type;

   // Tracks registers and phase, predicts each sample and checks the output
   class tone_tracker;
      bit [SR_W-1:0]    rate_reg = SR_RESET;
      bit [TONE_W-1:0]  tone_reg = TONE_RESET;
      bit [PHASE_W-1:0] phase = '0;
      tone_sample_type  expected_samples[$];
      int               mismatches = 0;
      int               results_checked = 0;
      int               ticks_taken = 0;
      int               ticks_ignored = 0;

      function void set_register(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         if (idx == CSR_SAMPLE_RATE)
            rate_reg = data[SR_W-1:0];
         else if (idx == CSR_TONE_HZ)
            tone_reg = data[TONE_W-1:0];
      endfunction

      function bit [63:0] period_length();
         bit [63:0] tone;
         bit [63:0] len;
         tone = (tone_reg == 0) ? 64'd1 : 64'(tone_reg);
         len = 64'(rate_reg) / tone;
         return (len == 0) ? 64'd1 : len;
      endfunction

      function bit [63:0] horner_step(bit [63:0] x2, bit [63:0] t, bit [63:0] d);
         return Q29_ONE - ((x2 * t) >> FRAC) / d;
      endfunction

      // Taylor series of sin on the folded angle, in Q29
      function bit [63:0] sine_magnitude(bit [63:0] x);
         bit [63:0] x2;
         bit [63:0] t;
         x2 = (x * x) >> FRAC;
         t = Q29_ONE - x2 / 64'd110;
         t = horner_step(x2, t, 64'd72);
         t = horner_step(x2, t, 64'd42);
         t = horner_step(x2, t, 64'd20);
         t = horner_step(x2, t, 64'd6);
         return (x * t) >> FRAC;
      endfunction

      function void note_failure(string msg);
         mismatches++;
         if (mismatches <= 10)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
      endfunction

      // For an accepted tick item, predict the sample, then advance the phase; count ignored items
      function void take_tick(bit tick);
         bit [63:0]       len;
         bit [63:0]       angle;
         bit [63:0]       mag;
         bit              negate;
         tone_sample_type exp_sample;
         if (!tick) begin
            ticks_ignored++;
            return;
         end
         ticks_taken++;
         len = period_length();
         angle = (64'd157 * 64'(phase) * Q29_ONE) / (64'd25 * len);
         angle = angle % ANGLE_FULL_TURN;
         negate = (angle >= ANGLE_HALF_TURN);
         if (negate)
            angle = angle - ANGLE_HALF_TURN;
         if (2 * angle > ANGLE_HALF_TURN)
            angle = ANGLE_HALF_TURN - angle;
         mag = (sine_magnitude(angle) * FULL_SCALE + Q29_HALF) >> FRAC;
         if (mag > FULL_SCALE)
            mag = FULL_SCALE;
         exp_sample.value = negate ? -mag[SAMPLE_W-1:0] : mag[SAMPLE_W-1:0];
         exp_sample.starts_period = (phase == 0);
         expected_samples.push_back(exp_sample);
         if (64'(phase) + 64'd1 >= len)
            phase = '0;
         else
            phase = phase + 1'b1;
      endfunction

      function void check_sample(logic [SAMPLE_W-1:0] got_value, logic got_start);
         tone_sample_type exp_sample;
         if (expected_samples.size() == 0) begin
            note_failure($sformatf("unexpected sample %0d", $signed(got_value)));
            return;
         end
         exp_sample = expected_samples.pop_front();
         results_checked++;
         if (got_value !== exp_sample.value)
            note_failure($sformatf("result %0d sample: expected %0d, got %0d",
                                   results_checked, $signed(exp_sample.value),
                                   $signed(got_value)));
         if (got_start !== exp_sample.starts_period)
            note_failure($sformatf("result %0d period_start: expected %0b, got %0b",
                                   results_checked, exp_sample.starts_period, got_start));
      endfunction

      function int pending_count();
         return expected_samples.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_tick = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_sample;
   logic rsp_period_start;
   logic csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_SAMPLE_RATE;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   tone_tracker board = new;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   logic hold_toggle = 1'b0;
   logic hold_seen = 1'b0;
   int hold_left = 0;
   int settings_used = 1;

   sine_tone_generator_core #(.SAMPLE_WIDTH(SAMPLE_W)) DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_tick         (req_tick),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sample       (rsp_sample),
      .rsp_period_start (rsp_period_start),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #HALF_PERIOD_NS clock = ~clock;

   // Check accepted samples; stall at random or hold off for a long stretch on request
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_sample(rsp_sample, rsp_period_start);
      if (hold_toggle != hold_seen) begin
         hold_seen <= hold_toggle;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Offer one item and return at the edge that accepts it; valid stays high
   task automatic send_tick(input bit tick_val);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_tick <= tick_val;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.take_tick(tick_val);
   endtask

   // Drop valid, wait for all samples to be checked, then wait out SETTLE_CYCLES
   task automatic quiesce();
      req_valid <= 1'b0;
      while (board.pending_count() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic configure(input logic [SR_W-1:0] rate, input logic [TONE_W-1:0] tone);
      quiesce();
      csr_we <= 1'b1;
      csr_index <= CSR_SAMPLE_RATE;
      csr_wdata <= CSR_DATA_W'(rate);
      @(posedge clock);
      board.set_register(CSR_SAMPLE_RATE, CSR_DATA_W'(rate));
      csr_index <= CSR_TONE_HZ;
      csr_wdata <= CSR_DATA_W'(tone);
      @(posedge clock);
      board.set_register(CSR_TONE_HZ, CSR_DATA_W'(tone));
      csr_we <= 1'b0;
      settings_used++;
   endtask

   task automatic send_ticks(input int count);
      repeat (count) send_tick(1'b1);
   endtask

   initial begin
      logic [SR_W-1:0] rate;
      logic [TONE_W-1:0] tone;
      int sent;
      bit tick_val;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Reset settings, with ignored items mixed in
      send_tick(1'b1);
      send_tick(1'b0);
      send_tick(1'b1);
      send_tick(1'b1);
      send_tick(1'b0);
      send_tick(1'b1);
      // Longest period: full rate, zero tone treated as one
      configure(18'h3FFFF, 16'd0);
      send_ticks(3);
      // Count now past a period of two
      configure(18'd10, 16'd5);
      send_ticks(3);
      // Tone above the rate holds the period at one
      configure(18'd100, 16'hFFFF);
      send_ticks(3);
      // Zero rate
      configure(18'd0, 16'd1);
      send_ticks(2);
      configure(18'd1, 16'd1);
      send_ticks(1);
      // Quarter-period steps reach both signs and the folds
      configure(18'd4, 16'd1);
      send_ticks(5);

      // Random phases, each with its own setting and idling mix
      for (int phase_idx = 0; phase_idx < RANDOM_PHASES; phase_idx++) begin
         case ($urandom_range(5))
            0: begin
               rate = SR_W'($urandom_range(262143, 1));
               tone = TONE_W'(rate / $urandom_range(64, 2));
            end
            1: begin
               rate = 18'd48000;
               tone = TONE_W'($urandom_range(4000, 200));
            end
            2: begin
               rate = 18'h3FFFF;
               tone = TONE_W'($urandom_range(65535, 4096));
            end
            3: begin
               rate = SR_W'($urandom_range(300, 1));
               tone = TONE_W'($urandom_range(65535, 0));
            end
            4: begin
               rate = SR_W'($urandom_range(262143, 0));
               tone = '0;
            end
            default: begin
               rate = SR_W'($urandom_range(100, 0));
               tone = TONE_W'($urandom_range(3, 0));
            end
         endcase
         configure(rate, tone);
         case (phase_idx % 4)
            0: begin
               send_idle_pct = 0;
               recv_stall_pct <= 0;
            end
            1: begin
               send_idle_pct = 80;
               recv_stall_pct <= 0;
            end
            2: begin
               send_idle_pct = 0;
               recv_stall_pct <= 80;
            end
            default: begin
               send_idle_pct = 35;
               recv_stall_pct <= 35;
            end
         endcase
         // Back up the output so the block stalls its input
         if (phase_idx == 0)
            hold_toggle <= ~hold_toggle;
         sent = 0;
         while (sent < TICKS_PER_PHASE) begin
            tick_val = ($urandom_range(9) != 0);
            send_tick(tick_val);
            if (tick_val)
               sent++;
         end
      end

      quiesce();
      if (board.pending_count() != 0)
         $display("%0d samples never arrived", board.pending_count());
      $display("Ran %0d sample ticks and %0d ignored ticks over %0d register settings.",
               board.ticks_taken, board.ticks_ignored, settings_used);
      $display("Checked %0d samples with idle mixes, back-pressure and period extremes.",
               board.results_checked);
      if (board.mismatches == 0 && board.pending_count() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("Timeout with %0d samples outstanding", board.pending_count());
      $display("Test completed with failures");
      $finish;
   end

endmodule

FILE: sine_tone_generator_core.f
sv/stg_pkg.sv
sv/stg_div.sv
sv/stg_dp.sv
sv/stg_ctrl.sv
sv/sine_tone_generator_core.sv
sv/stg_checker.sv
test/testbench.sv
